/* rtl/dbsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsc_pkg
// Shared constants, register indexes and types of the blob shape counter.
// ----------------------------------------------------------------------------
package dbsc_pkg;

  localparam int unsigned DEF_MAX_ROWS   = 32;
  localparam int unsigned DEF_MAX_COLS   = 32;
  localparam int unsigned DEF_MAX_SHAPES = 512;

  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_W     = 10;

  localparam logic [CFG_W-1:0]     CFG_RESET     = 6'd32;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_POP_RD,
    S_POP_WAIT,
    S_NB,
    S_NB_CHK,
    S_MATCH_INIT,
    S_TAB_RD,
    S_TAB_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_NEW,
    S_COPY_RD,
    S_COPY_WR,
    S_SCAN_NEXT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic we;
    logic data;
    logic last;
  } load_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

/* rtl/dbsc_loader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsc_loader
// Size registers and the raster counters that place incoming cells.
// ----------------------------------------------------------------------------
module dbsc_loader #(
  parameter int unsigned MAX_ROWS = dbsc_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = dbsc_pkg::DEF_MAX_COLS,
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned DRW = $clog2(MAX_ROWS + 1),
  localparam int unsigned DCW = $clog2(MAX_COLS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dbsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dbsc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           accept_i,
  input  logic                           cell_i,
  output logic [DRW-1:0]                 rows_o,
  output logic [DCW-1:0]                 cols_o,
  output dbsc_pkg::load_ctl_t            load_o,
  output logic [RW+CW-1:0]               load_addr_o
);

  logic [dbsc_pkg::CFG_W-1:0] rows_q, cols_q;
  logic [RW-1:0] lr_q, lr_d;
  logic [CW-1:0] lc_q, lc_d;
  logic          row_last, col_last;

  always_comb begin
    if (rows_q == '0) begin
      rows_o = DRW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_o = DRW'(MAX_ROWS);
    end else begin
      rows_o = DRW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_o = DCW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_o = DCW'(MAX_COLS);
    end else begin
      cols_o = DCW'(cols_q);
    end
  end

  assign row_last = (DRW'(lr_q) + DRW'(1)) == rows_o;
  assign col_last = (DCW'(lc_q) + DCW'(1)) == cols_o;

  always_comb begin
    lr_d = lr_q;
    lc_d = lc_q;
    if (cfg_we_i) begin
      lr_d = '0;
      lc_d = '0;
    end else if (accept_i) begin
      if (col_last) begin
        lc_d = '0;
        lr_d = row_last ? '0 : lr_q + RW'(1);
      end else begin
        lc_d = lc_q + CW'(1);
      end
    end
  end

  assign load_o.we    = accept_i;
  assign load_o.data  = cell_i;
  assign load_o.last  = row_last && col_last;
  assign load_addr_o  = {lr_q, lc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= dbsc_pkg::CFG_RESET;
      cols_q <= dbsc_pkg::CFG_RESET;
      lr_q   <= '0;
      lc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dbsc_pkg::REG_ROW_COUNT: rows_q <= cfg_data_i;
          dbsc_pkg::REG_COL_COUNT: cols_q <= cfg_data_i;
          default: ;
        endcase
      end
      lr_q <= lr_d;
      lc_q <= lc_d;
    end
  end

endmodule

/* rtl/dbsc_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsc_engine
// Sequencer for raster scan, queue-based flood fill and shape matching.
// ----------------------------------------------------------------------------
module dbsc_engine #(
  parameter int unsigned MAX_ROWS   = dbsc_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = dbsc_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_SHAPES = dbsc_pkg::DEF_MAX_SHAPES,
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned DRW   = $clog2(MAX_ROWS + 1),
  localparam int unsigned DCW   = $clog2(MAX_COLS + 1),
  localparam int unsigned AW    = RW + CW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [DRW-1:0]                rows_i,
  input  logic [DCW-1:0]                cols_i,
  input  dbsc_pkg::load_ctl_t           load_i,
  input  logic [AW-1:0]                 load_addr_i,
  input  logic                          ack_i,
  output dbsc_pkg::eng_stat_t           stat_o,
  output logic [dbsc_pkg::OUT_W-1:0]    total_o,
  output logic [dbsc_pkg::OUT_W-1:0]    distinct_o
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned QW    = $clog2(CELLS + 1);
  localparam int unsigned QAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned OW    = RW + CW + 1;
  localparam int unsigned TW    = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int unsigned SW    = $clog2(MAX_SHAPES + 1);

  dbsc_pkg::state_e state_q, state_d;

  logic [RW-1:0] sr_q, sr_d, cur_r_q, cur_r_d, seed_r_q, seed_r_d, nb_r_q, nb_r_d;
  logic [CW-1:0] sc_q, sc_d, cur_c_q, cur_c_d, seed_c_q, seed_c_d, nb_c_q, nb_c_d;
  logic [1:0]    dir_q, dir_d;
  logic [QW-1:0] head_q, head_d, tail_q, tail_d, k_q, k_d, base_q, base_d, wp_q, wp_d;
  logic [SW-1:0] s_q, s_d, stored_q, stored_d;
  logic [dbsc_pkg::OUT_W-1:0] total_q, total_d, distinct_q, distinct_d;

  logic            img_mem [2**AW];
  logic [AW-1:0]   q_mem [CELLS];
  logic [OW-1:0]   offs_mem [CELLS];
  logic [2*QW-1:0] tab_mem [MAX_SHAPES];

  logic            img_rd_q;
  logic [AW-1:0]   q_rd_q;
  logic [OW-1:0]   offs_rd_q;
  logic [2*QW-1:0] tab_rd_q;

  logic            img_we, img_wbit, img_re;
  logic [AW-1:0]   img_waddr, img_raddr;
  logic            q_we, q_re;
  logic [QAW-1:0]  q_waddr, q_raddr;
  logic [AW-1:0]   q_wdata;
  logic            offs_we, offs_re;
  logic [QAW-1:0]  offs_waddr, offs_raddr;
  logic            tab_we, tab_re;
  logic [TW-1:0]   tab_waddr, tab_raddr;
  logic [2*QW-1:0] tab_wdata;

  logic            nb_ok;
  logic [RW-1:0]   nb_r;
  logic [CW-1:0]   nb_c;
  logic [OW-1:0]   q_off;
  logic            row_last, col_last, len_eq, q_empty, k_end, tab_room, dir_end;
  logic [QW-1:0]   offs_idx;

  always_comb begin
    nb_ok = 1'b0;
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    case (dir_q)
      dbsc_pkg::DIR_DOWN: begin
        nb_ok = (DRW'(cur_r_q) + DRW'(1)) < rows_i;
        nb_r  = cur_r_q + RW'(1);
      end
      dbsc_pkg::DIR_UP: begin
        nb_ok = cur_r_q != '0;
        nb_r  = cur_r_q - RW'(1);
      end
      dbsc_pkg::DIR_RIGHT: begin
        nb_ok = (DCW'(cur_c_q) + DCW'(1)) < cols_i;
        nb_c  = cur_c_q + CW'(1);
      end
      dbsc_pkg::DIR_LEFT: begin
        nb_ok = cur_c_q != '0;
        nb_c  = cur_c_q - CW'(1);
      end
      default: ;
    endcase
  end

  assign q_off    = {q_rd_q[AW-1:CW] - seed_r_q,
                     {1'b0, q_rd_q[CW-1:0]} - {1'b0, seed_c_q}};
  assign row_last = (DRW'(sr_q) + DRW'(1)) == rows_i;
  assign col_last = (DCW'(sc_q) + DCW'(1)) == cols_i;
  assign len_eq   = tab_rd_q[QW-1:0] == tail_q;
  assign q_empty  = head_q == tail_q;
  assign k_end    = k_q == tail_q;
  assign tab_room = int'(stored_q) < MAX_SHAPES;
  assign dir_end  = dir_q == dbsc_pkg::DIR_LEFT;
  assign offs_idx = base_q + k_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dbsc_pkg::S_IDLE:       if (load_i.we && load_i.last) state_d = dbsc_pkg::S_SCAN_RD;
      dbsc_pkg::S_SCAN_RD:    state_d = dbsc_pkg::S_SCAN_CHK;
      dbsc_pkg::S_SCAN_CHK:   state_d = img_rd_q ? dbsc_pkg::S_POP_RD : dbsc_pkg::S_SCAN_NEXT;
      dbsc_pkg::S_POP_RD:     state_d = q_empty ? dbsc_pkg::S_MATCH_INIT : dbsc_pkg::S_POP_WAIT;
      dbsc_pkg::S_POP_WAIT:   state_d = dbsc_pkg::S_NB;
      dbsc_pkg::S_NB: begin
        if (nb_ok) begin
          state_d = dbsc_pkg::S_NB_CHK;
        end else if (dir_end) begin
          state_d = dbsc_pkg::S_POP_RD;
        end
      end
      dbsc_pkg::S_NB_CHK:     state_d = dir_end ? dbsc_pkg::S_POP_RD : dbsc_pkg::S_NB;
      dbsc_pkg::S_MATCH_INIT: state_d = dbsc_pkg::S_TAB_RD;
      dbsc_pkg::S_TAB_RD:     state_d = (s_q == stored_q) ? dbsc_pkg::S_NEW : dbsc_pkg::S_TAB_CHK;
      dbsc_pkg::S_TAB_CHK:    state_d = len_eq ? dbsc_pkg::S_CMP_RD : dbsc_pkg::S_TAB_RD;
      dbsc_pkg::S_CMP_RD:     state_d = k_end ? dbsc_pkg::S_SCAN_NEXT : dbsc_pkg::S_CMP_CHK;
      dbsc_pkg::S_CMP_CHK:    state_d = (q_off == offs_rd_q) ? dbsc_pkg::S_CMP_RD
                                                             : dbsc_pkg::S_TAB_RD;
      dbsc_pkg::S_NEW:        state_d = tab_room ? dbsc_pkg::S_COPY_RD : dbsc_pkg::S_SCAN_NEXT;
      dbsc_pkg::S_COPY_RD:    state_d = k_end ? dbsc_pkg::S_SCAN_NEXT : dbsc_pkg::S_COPY_WR;
      dbsc_pkg::S_COPY_WR:    state_d = dbsc_pkg::S_COPY_RD;
      dbsc_pkg::S_SCAN_NEXT:  state_d = (row_last && col_last) ? dbsc_pkg::S_DONE
                                                               : dbsc_pkg::S_SCAN_RD;
      dbsc_pkg::S_DONE:       if (ack_i) state_d = dbsc_pkg::S_IDLE;
      default:                state_d = dbsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sr_d = sr_q;         sc_d = sc_q;
    cur_r_d = cur_r_q;   cur_c_d = cur_c_q;
    seed_r_d = seed_r_q; seed_c_d = seed_c_q;
    nb_r_d = nb_r_q;     nb_c_d = nb_c_q;
    dir_d = dir_q;       head_d = head_q;   tail_d = tail_q;
    k_d = k_q;           base_d = base_q;   wp_d = wp_q;
    s_d = s_q;           stored_d = stored_q;
    total_d = total_q;   distinct_d = distinct_q;
    img_we = 1'b0;  img_waddr = load_addr_i; img_wbit = load_i.data;
    img_re = 1'b0;  img_raddr = {sr_q, sc_q};
    q_we = 1'b0;    q_waddr = tail_q[QAW-1:0]; q_wdata = {nb_r_q, nb_c_q};
    q_re = 1'b0;    q_raddr = k_q[QAW-1:0];
    offs_we = 1'b0; offs_waddr = wp_q[QAW-1:0];
    offs_re = 1'b0; offs_raddr = offs_idx[QAW-1:0];
    tab_we = 1'b0;  tab_waddr = stored_q[TW-1:0]; tab_wdata = {wp_q, tail_q};
    tab_re = 1'b0;  tab_raddr = s_q[TW-1:0];
    case (state_q)
      dbsc_pkg::S_IDLE: begin
        img_we = load_i.we;
        if (load_i.we && load_i.last) begin
          sr_d = '0; sc_d = '0;
          total_d = '0; distinct_d = '0;
          stored_d = '0; wp_d = '0;
        end
      end
      dbsc_pkg::S_SCAN_RD: img_re = 1'b1;
      dbsc_pkg::S_SCAN_CHK: begin
        if (img_rd_q) begin
          seed_r_d  = sr_q;
          seed_c_d  = sc_q;
          img_we    = 1'b1;
          img_waddr = {sr_q, sc_q};
          img_wbit  = 1'b0;
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {sr_q, sc_q};
          tail_d    = QW'(1);
          head_d    = '0;
        end
      end
      dbsc_pkg::S_POP_RD: begin
        q_re    = !q_empty;
        q_raddr = head_q[QAW-1:0];
      end
      dbsc_pkg::S_POP_WAIT: begin
        cur_r_d = q_rd_q[AW-1:CW];
        cur_c_d = q_rd_q[CW-1:0];
        head_d  = head_q + QW'(1);
        dir_d   = dbsc_pkg::DIR_DOWN;
      end
      dbsc_pkg::S_NB: begin
        if (nb_ok) begin
          img_re    = 1'b1;
          img_raddr = {nb_r, nb_c};
          nb_r_d    = nb_r;
          nb_c_d    = nb_c;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      dbsc_pkg::S_NB_CHK: begin
        if (img_rd_q) begin
          img_we    = 1'b1;
          img_waddr = {nb_r_q, nb_c_q};
          img_wbit  = 1'b0;
          q_we      = 1'b1;
          tail_d    = tail_q + QW'(1);
        end
        dir_d = dir_q + 2'd1;
      end
      dbsc_pkg::S_MATCH_INIT: begin
        total_d = total_q + dbsc_pkg::OUT_W'(1);
        s_d     = '0;
      end
      dbsc_pkg::S_TAB_RD: tab_re = s_q != stored_q;
      dbsc_pkg::S_TAB_CHK: begin
        if (len_eq) begin
          k_d    = '0;
          base_d = tab_rd_q[2*QW-1:QW];
        end else begin
          s_d = s_q + SW'(1);
        end
      end
      dbsc_pkg::S_CMP_RD: begin
        q_re    = !k_end;
        offs_re = !k_end;
      end
      dbsc_pkg::S_CMP_CHK: begin
        if (q_off == offs_rd_q) begin
          k_d = k_q + QW'(1);
        end else begin
          s_d = s_q + SW'(1);
        end
      end
      dbsc_pkg::S_NEW: begin
        distinct_d = distinct_q + dbsc_pkg::OUT_W'(1);
        if (tab_room) begin
          tab_we   = 1'b1;
          stored_d = stored_q + SW'(1);
          k_d      = '0;
        end
      end
      dbsc_pkg::S_COPY_RD: q_re = !k_end;
      dbsc_pkg::S_COPY_WR: begin
        offs_we = 1'b1;
        wp_d    = wp_q + QW'(1);
        k_d     = k_q + QW'(1);
      end
      dbsc_pkg::S_SCAN_NEXT: begin
        if (col_last) begin
          sc_d = '0;
          if (!row_last) begin
            sr_d = sr_q + RW'(1);
          end
        end else begin
          sc_d = sc_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.idle = state_q == dbsc_pkg::S_IDLE;
  assign stat_o.done = state_q == dbsc_pkg::S_DONE;
  assign total_o     = total_q;
  assign distinct_o  = distinct_q;

  always_ff @(posedge clk_i) begin
    if (img_we) img_mem[img_waddr] <= img_wbit;
    if (img_re) img_rd_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd_q <= q_mem[q_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (offs_we) offs_mem[offs_waddr] <= q_off;
    if (offs_re) offs_rd_q <= offs_mem[offs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    if (tab_re) tab_rd_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dbsc_pkg::S_IDLE;
      total_q    <= '0;
      distinct_q <= '0;
      stored_q   <= '0;
      wp_q       <= '0;
      head_q     <= '0;
      tail_q     <= '0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      distinct_q <= distinct_d;
      stored_q   <= stored_d;
      wp_q       <= wp_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q     <= sr_d;     sc_q     <= sc_d;
    cur_r_q  <= cur_r_d;  cur_c_q  <= cur_c_d;
    seed_r_q <= seed_r_d; seed_c_q <= seed_c_d;
    nb_r_q   <= nb_r_d;   nb_c_q   <= nb_c_d;
    dir_q    <= dir_d;    k_q      <= k_d;
    base_q   <= base_d;   s_q      <= s_d;
  end

endmodule

/* rtl/distinct_blob_shape_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_blob_shape_counter
// Counts 4-connected blobs of a binary image and their distinct shapes.
// ----------------------------------------------------------------------------
// Cells arrive on the input channel one request per cycle while the block is
// idle, in row-major order, row_count by col_count cells per image. The size
// registers are to be written over the plain write port only while the block
// is idle; the block itself does not enforce this. A write restarts loading.
// After the last cell the engine scans the image, floods each blob through a
// work queue and matches its cell offsets, relative to its first cell in scan
// order, against the stored shapes. Input is not ready during this phase.
// Processing walks each image cell of the scan, each blob cell taken from the
// queue, each neighbor probe inside the image or off its edge, each stored
// shape checked, each cell compared and each cell of each new shape stored;
// each memory serves one read and one write per cycle, and this sets the pace.
// One result request then carries both counts; it becomes valid once the
// finished result is taken into the output register. It sits there while the
// receiver stalls, and the next image may load meanwhile.
// Reset sets both sizes to 32 and empties the pipeline; memories are not
// cleared, since every entry that is read was written first.
// ----------------------------------------------------------------------------
module distinct_blob_shape_counter #(
  parameter int unsigned MAX_ROWS   = dbsc_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS   = dbsc_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_SHAPES = dbsc_pkg::DEF_MAX_SHAPES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dbsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dbsc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_cell_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dbsc_pkg::OUT_W-1:0]     out_total_figures_o,
  output logic [dbsc_pkg::OUT_W-1:0]     out_distinct_figures_o
);

  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned DCW = $clog2(MAX_COLS + 1);

  logic [DRW-1:0]             rows;
  logic [DCW-1:0]             cols;
  dbsc_pkg::load_ctl_t        load;
  logic [RW+CW-1:0]           load_addr;
  dbsc_pkg::eng_stat_t        stat;
  logic [dbsc_pkg::OUT_W-1:0] total, distinct;
  logic                       accept, ack;
  logic                       out_valid_q;
  logic [dbsc_pkg::OUT_W-1:0] total_q, distinct_q;

  assign in_ready_o = stat.idle;
  assign accept     = in_valid_i && in_ready_o;
  assign ack        = stat.done && (!out_valid_q || out_ready_i);

  dbsc_loader #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_loader (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cell_i     (in_cell_req_i),
    .rows_o     (rows),
    .cols_o     (cols),
    .load_o     (load),
    .load_addr_o(load_addr)
  );

  dbsc_engine #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_SHAPES(MAX_SHAPES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rows_i     (rows),
    .cols_i     (cols),
    .load_i     (load),
    .load_addr_i(load_addr),
    .ack_i      (ack),
    .stat_o     (stat),
    .total_o    (total),
    .distinct_o (distinct)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      total_q    <= total;
      distinct_q <= distinct;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_total_figures_o    = total_q;
  assign out_distinct_figures_o = distinct_q;

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack |=> out_valid_o)
    else $error("finished result did not reach the output register");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && load.last |=> !in_ready_o)
    else $error("input still ready after the last cell of an image");

  a_no_ack_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !ack)
    else $error("result overwrote a stalled output");

endmodule

/* tb/sv/distinct_blob_shape_counter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distinct_blob_shape_counter_test
// Self-checking bench for the blob and distinct shape counter.
// ----------------------------------------------------------------------------
// Images of many sizes are streamed in cell by cell with random gaps on both
// channels. A behavioral flood fill predicts both counts for every completed
// image, and each result is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module distinct_blob_shape_counter_test;

  typedef struct {
    logic [dbsc_pkg::OUT_W-1:0] total;
    logic [dbsc_pkg::OUT_W-1:0] distinct;
  } fig_counts_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [dbsc_pkg::CFG_IDX_W-1:0] cfg_idx = dbsc_pkg::REG_ROW_COUNT;
  logic [dbsc_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_cell = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dbsc_pkg::OUT_W-1:0]     out_total;
  logic [dbsc_pkg::OUT_W-1:0]     out_distinct;

  bit          pending_cells[$];
  fig_counts_t expected_counts[$];
  bit          image_cells[1024];
  int          img_rows = 32;
  int          img_cols = 32;
  int          cells_in = 0;
  int          cycle_cnt = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          stall_left = 0;
  bit          stall_done = 1'b0;

  distinct_blob_shape_counter i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we),
    .cfg_idx_i              (cfg_idx),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .in_cell_req_i          (in_cell),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .out_total_figures_o    (out_total),
    .out_distinct_figures_o (out_distinct)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_size(input logic [dbsc_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  function automatic fig_counts_t count_figures(input int rows, input int cols);
    bit          work[1024];
    int          fifo[$];
    int          members[$];
    bit [1023:0] shape_lib[$];
    bit [1023:0] bitmap;
    int          blobs;
    int          shapes;
    int          idx;
    int          rr;
    int          cc;
    int          mr;
    int          mc;
    bit          found;
    fig_counts_t res;
    work = image_cells;
    blobs = 0;
    shapes = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (work[r*32+c]) begin
          work[r*32+c] = 1'b0;
          fifo = {r*32+c};
          members = {};
          mr = r;
          mc = c;
          while (fifo.size() > 0) begin
            idx = fifo.pop_front();
            members = {members, idx};
            rr = idx / 32;
            cc = idx % 32;
            if (rr < mr) mr = rr;
            if (cc < mc) mc = cc;
            if (rr + 1 < rows && work[idx+32]) begin
              work[idx+32] = 1'b0;
              fifo = {fifo, idx + 32};
            end
            if (rr > 0 && work[idx-32]) begin
              work[idx-32] = 1'b0;
              fifo = {fifo, idx - 32};
            end
            if (cc + 1 < cols && work[idx+1]) begin
              work[idx+1] = 1'b0;
              fifo = {fifo, idx + 1};
            end
            if (cc > 0 && work[idx-1]) begin
              work[idx-1] = 1'b0;
              fifo = {fifo, idx - 1};
            end
          end
          bitmap = '0;
          foreach (members[k]) begin
            bitmap[(members[k]/32 - mr)*32 + (members[k]%32 - mc)] = 1'b1;
          end
          blobs++;
          found = 1'b0;
          foreach (shape_lib[s]) begin
            if (shape_lib[s] == bitmap) found = 1'b1;
          end
          if (!found) begin
            shape_lib = {shape_lib, bitmap};
            shapes++;
          end
        end
      end
    end
    res.total = blobs[dbsc_pkg::OUT_W-1:0];
    res.distinct = shapes[dbsc_pkg::OUT_W-1:0];
    return res;
  endfunction

  // Sender: one request per cell, held until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_cell <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        image_cells[(cells_in / img_cols) * 32 + cells_in % img_cols] = in_cell;
        cells_in++;
        if (cells_in == img_rows * img_cols) begin
          expected_counts = {expected_counts, count_figures(img_rows, img_cols)};
          cells_in = 0;
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_cells.size() > 0 &&
            ((cycle_cnt > 3000 && cycle_cnt < 6000) || $urandom_range(99) >= 27)) begin
          in_valid <= 1'b1;
          in_cell <= pending_cells.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver with random stalls and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      cycle_cnt++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!stall_done && results_seen == 15) begin
        stall_done = 1'b1;
        stall_left = 1500;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (cycle_cnt > 3000 && cycle_cnt < 6000) || $urandom_range(99) >= 27;
      end
    end
  end

  always @(posedge clk_i) begin
    fig_counts_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %0d/%0d", out_total, out_distinct);
      end else begin
        want = expected_counts.pop_front();
        if (out_total !== want.total || out_distinct !== want.distinct) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0d, got %0d/%0d",
                     want.total, want.distinct, out_total, out_distinct);
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cells.size() > 0 || in_valid || expected_counts.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [dbsc_pkg::CFG_IDX_W-1:0] idx,
                            input logic [dbsc_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == dbsc_pkg::REG_ROW_COUNT) img_rows = clamp_size(val);
    else img_cols = clamp_size(val);
    cells_in = 0;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_dims(input logic [dbsc_pkg::CFG_W-1:0] rows,
                          input logic [dbsc_pkg::CFG_W-1:0] cols);
    wait_idle();
    write_size(dbsc_pkg::REG_ROW_COUNT, rows);
    write_size(dbsc_pkg::REG_COL_COUNT, cols);
  endtask

  task automatic queue_random(input int n_images, input int density);
    repeat (n_images * img_rows * img_cols)
      pending_cells = {pending_cells, bit'($urandom_range(99) < density)};
  endtask

  task automatic queue_bits(input bit [63:0] pattern, input int n);
    for (int i = 0; i < n; i++) pending_cells = {pending_cells, pattern[i]};
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_dims(6'd0, 6'd1);
    queue_bits(64'b10, 2);
    set_dims(6'd2, 6'd2);
    queue_bits(64'b1111, 4);
    queue_bits(64'b1001, 4);
    queue_bits(64'b0000, 4);
    set_dims(6'd3, 6'd3);
    queue_bits(64'b010_111_010, 9);
    queue_bits(64'b101_000_101, 9);
    queue_bits(64'b110_011_001, 9);
    wait_idle();
    // A partial image is dropped when a size register is written.
    queue_bits(64'b111, 3);
    set_dims(6'd2, 6'd3);
    queue_bits(64'b011_110, 6);
    set_dims(6'd16, 6'd16);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) pending_cells = {pending_cells, bit'(((r + c) % 2) == 0)};
    set_dims(6'd1, 6'd63);
    queue_random(1, 50);
    set_dims(6'd32, 6'd1);
    queue_random(1, 50);
    set_dims(6'd3, 6'd4);
    queue_random(15, 45);
    for (int p = 0; p < 7; p++) begin
      set_dims(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)));
      queue_random(2, $urandom_range(0, 100));
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
